FILE: hdl/grouped_team_queue_assert.svh
// Assertion macros for the grouped team queue checker.
// Both macros expect i_clk and i_rst_n in scope.
`ifndef GROUPED_TEAM_QUEUE_ASSERT_SVH
`define GROUPED_TEAM_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define GTQ_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GTQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/gtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtq_pkg
// Shared types and constants of the grouped team queue.
// ----------------------------------------------------------------------------
package gtq_pkg;

    localparam int ID_W            = 10;
    localparam int CLS_W           = 10;
    localparam int DEF_MAX_MEMBERS = 1024;
    localparam int DEF_MAX_CLASSES = 1024;
    localparam int S_TDATA_W       = 24;
    localparam int S_TUSER_W       = 2;
    localparam int M_TDATA_W       = 16;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ENQ  = 2'd1,
        CMD_DEQ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A,
        ST_B,
        ST_C
    } t_state;

    // per-member entry: class, loaded, queued
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic             known;
        logic             queued;
    } t_info;

    // per-class entry: list ends and waiting flag
    typedef struct packed {
        logic            waiting;
        logic [ID_W-1:0] tail;
        logic [ID_W-1:0] head;
    } t_cls_ent;

endpackage

FILE: hdl/gtq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gtq_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/grouped_team_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_team_queue
// Team queue: members join behind the last waiting member of their class,
// classes are served in ring order. State lives in four table RAMs.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                              | tuser
//  s_*     | in        | [9:0] member_id, [19:10] class_id  | [1:0] command
//  m_*     | out       | [9:0] member_out                   | [0] empty_res
//
//  Steps per word: load, unused code and ignored enqueue end in ST_A,
//  enqueue in ST_B, dequeue in ST_A when empty and in ST_C otherwise;
//  each step waits on one RAM read. After reset a clearing pass zeroes
//  the member and class tables; s_tready stays low meanwhile.
//  One word is in work at a time. Loads and enqueues are taken while a
//  result waits on m_*; a dequeue waits until the result slot is free.
// ----------------------------------------------------------------------------
module grouped_team_queue #(
    parameter int MAX_MEMBERS = gtq_pkg::DEF_MAX_MEMBERS,
    parameter int MAX_CLASSES = gtq_pkg::DEF_MAX_CLASSES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [gtq_pkg::S_TDATA_W-1:0] s_tdata,  // member_id, class_id
    input  logic [gtq_pkg::S_TUSER_W-1:0] s_tuser,  // command
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gtq_pkg::M_TDATA_W-1:0] m_tdata,  // member_out
    output logic                         m_tuser    // empty_res
);

    import gtq_pkg::*;

    localparam int MW    = $clog2(MAX_MEMBERS);
    localparam int CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int N_CLR = (MAX_MEMBERS > MAX_CLASSES) ? MAX_MEMBERS : MAX_CLASSES;
    localparam int CLRW  = $clog2(N_CLR);

    t_state          r_state, n_state;
    t_cmd            r_cmd;
    logic [ID_W-1:0] r_mid;
    logic [CLS_W-1:0] r_cid;
    logic [CLS_W-1:0] r_cls;
    logic [CLRW-1:0] r_clr;
    logic [CW-1:0]   r_ring_head;
    logic [CW:0]     r_ring_count;
    logic            r_out_valid;
    logic [ID_W-1:0] r_out_member;
    logic            r_out_empty;

    // RAM ports
    logic            w_info_we;
    logic [MW-1:0]   w_info_waddr, w_info_raddr;
    t_info           w_info_wdata, w_info_rd;
    logic            w_next_we;
    logic [MW-1:0]   w_next_waddr, w_next_raddr;
    logic [ID_W-1:0] w_next_wdata, w_next_rd;
    logic            w_cls_we;
    logic [CW-1:0]   w_cls_waddr, w_cls_raddr;
    t_cls_ent        w_cls_wdata, w_cls_rd;
    logic            w_ring_we;
    logic [CW-1:0]   w_ring_waddr;
    logic [CLS_W-1:0] w_ring_wdata, w_ring_rd;

    logic            w_accept;
    logic            w_mid_ok, w_cid_ok, w_enq_go;
    logic            w_ring_empty, w_deq_last;
    logic [CW+1:0]   w_slot_sum;
    logic [CW-1:0]   w_slot, w_head_inc;

    assign w_accept     = s_tvalid && s_tready;
    assign w_mid_ok     = 32'(r_mid) < MAX_MEMBERS;
    assign w_cid_ok     = 32'(r_cid) < MAX_CLASSES;
    assign w_enq_go     = w_mid_ok && w_info_rd.known && !w_info_rd.queued;
    assign w_ring_empty = (r_ring_count == '0);
    assign w_deq_last   = (w_cls_rd.head == w_cls_rd.tail);
    assign w_slot_sum   = (CW+2)'(r_ring_head) + (CW+2)'(r_ring_count);
    assign w_slot       = (w_slot_sum >= (CW+2)'(MAX_CLASSES))
                        ? CW'(w_slot_sum - (CW+2)'(MAX_CLASSES)) : CW'(w_slot_sum);
    assign w_head_inc   = (r_ring_head == CW'(MAX_CLASSES - 1))
                        ? '0 : r_ring_head + CW'(1);

    // a dequeue needs the result slot free by the time it finishes
    assign s_tready = (r_state == ST_IDLE)
                   && (!r_out_valid || m_tready || (s_tuser != CMD_DEQ));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLRW'(N_CLR - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) n_state = ST_A;
            end
            ST_A: begin
                case (r_cmd)
                    CMD_ENQ: n_state = w_enq_go ? ST_B : ST_IDLE;
                    CMD_DEQ: n_state = w_ring_empty ? ST_IDLE : ST_B;
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_B: begin
                n_state = (r_cmd == CMD_DEQ) ? ST_C : ST_IDLE;
            end
            ST_C: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // table accesses
    always_comb begin
        w_info_we    = 1'b0;
        w_info_waddr = MW'(r_mid);
        w_info_wdata = '0;
        w_info_raddr = MW'(r_mid);
        w_next_we    = 1'b0;
        w_next_waddr = MW'(w_cls_rd.tail);
        w_next_wdata = r_mid;
        w_next_raddr = MW'(w_cls_rd.head);
        w_cls_we     = 1'b0;
        w_cls_waddr  = CW'(r_cls);
        w_cls_wdata  = '0;
        w_cls_raddr  = CW'(r_cls);
        w_ring_we    = 1'b0;
        w_ring_waddr = w_slot;
        w_ring_wdata = r_cls;
        case (r_state)
            ST_CLEAR: begin
                w_info_waddr = MW'(r_clr);
                w_cls_waddr  = CW'(r_clr);
                w_info_we    = 32'(r_clr) < MAX_MEMBERS;
                w_cls_we     = 32'(r_clr) < MAX_CLASSES;
            end
            ST_IDLE: begin
                w_info_raddr = MW'(s_tdata[ID_W-1:0]);
            end
            ST_A: begin
                w_cls_raddr = (r_cmd == CMD_ENQ) ? CW'(w_info_rd.cls) : CW'(w_ring_rd);
                case (r_cmd)
                    CMD_LOAD: begin
                        w_info_we    = w_mid_ok && w_cid_ok;
                        w_info_wdata = '{cls: r_cid, known: 1'b1,
                                         queued: w_info_rd.queued};
                    end
                    CMD_ENQ: begin
                        w_info_we    = w_enq_go;
                        w_info_wdata = '{cls: w_info_rd.cls, known: 1'b1, queued: 1'b1};
                    end
                    default: ;
                endcase
            end
            ST_B: begin
                w_info_raddr = MW'(w_cls_rd.head);
                if (r_cmd == CMD_ENQ) begin
                    w_cls_we = 1'b1;
                    if (w_cls_rd.waiting) begin
                        // append behind the last waiting member of the class
                        w_next_we   = 1'b1;
                        w_cls_wdata = '{waiting: 1'b1, tail: r_mid, head: w_cls_rd.head};
                    end else begin
                        // open the class at the ring tail
                        w_ring_we   = 1'b1;
                        w_cls_wdata = '{waiting: 1'b1, tail: r_mid, head: r_mid};
                    end
                end
            end
            ST_C: begin
                w_info_we    = 1'b1;
                w_info_waddr = MW'(w_cls_rd.head);
                w_info_wdata = '{cls: w_info_rd.cls, known: w_info_rd.known,
                                 queued: 1'b0};
                w_cls_we     = 1'b1;
                if (w_deq_last) begin
                    w_cls_wdata = '{waiting: 1'b0, tail: w_cls_rd.tail,
                                    head: w_cls_rd.head};
                end else begin
                    w_cls_wdata = '{waiting: 1'b1, tail: w_cls_rd.tail, head: w_next_rd};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_ring_head  <= '0;
            r_ring_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + CLRW'(1);
            end
            if ((r_state == ST_C)
                    || (r_state == ST_A && r_cmd == CMD_DEQ && w_ring_empty)) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_B && r_cmd == CMD_ENQ && !w_cls_rd.waiting
                    && r_ring_count < (CW+1)'(MAX_CLASSES)) begin
                r_ring_count <= r_ring_count + (CW+1)'(1);
            end
            if (r_state == ST_C) begin
                if (w_deq_last) begin
                    r_ring_head  <= w_head_inc;
                    r_ring_count <= r_ring_count - (CW+1)'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(s_tuser);
            r_mid <= s_tdata[ID_W-1:0];
            r_cid <= s_tdata[ID_W+CLS_W-1:ID_W];
        end
        if (r_state == ST_A) begin
            r_cls <= (r_cmd == CMD_ENQ) ? w_info_rd.cls : w_ring_rd;
            if (r_cmd == CMD_DEQ && w_ring_empty) begin
                r_out_member <= '0;
                r_out_empty  <= 1'b1;
            end
        end
        if (r_state == ST_C) begin
            r_out_member <= w_cls_rd.head;
            r_out_empty  <= 1'b0;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = M_TDATA_W'(r_out_member);
    assign m_tuser  = r_out_empty;

    gtq_ram #(.WIDTH($bits(t_info)), .DEPTH(MAX_MEMBERS)) u_info_ram (
        .i_clk  (i_clk),
        .i_we   (w_info_we),
        .i_waddr(w_info_waddr),
        .i_wdata(w_info_wdata),
        .i_raddr(w_info_raddr),
        .o_rdata(w_info_rd)
    );

    gtq_ram #(.WIDTH(ID_W), .DEPTH(MAX_MEMBERS)) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (w_next_we),
        .i_waddr(w_next_waddr),
        .i_wdata(w_next_wdata),
        .i_raddr(w_next_raddr),
        .o_rdata(w_next_rd)
    );

    gtq_ram #(.WIDTH($bits(t_cls_ent)), .DEPTH(MAX_CLASSES)) u_cls_ram (
        .i_clk  (i_clk),
        .i_we   (w_cls_we),
        .i_waddr(w_cls_waddr),
        .i_wdata(w_cls_wdata),
        .i_raddr(w_cls_raddr),
        .o_rdata(w_cls_rd)
    );

    gtq_ram #(.WIDTH(CLS_W), .DEPTH(MAX_CLASSES)) u_ring_ram (
        .i_clk  (i_clk),
        .i_we   (w_ring_we),
        .i_waddr(w_ring_waddr),
        .i_wdata(w_ring_wdata),
        .i_raddr(r_ring_head),
        .o_rdata(w_ring_rd)
    );

endmodule

FILE: hdl/gtq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtq_checker
// Port-level checks of the grouped team queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "grouped_team_queue_assert.svh"

module gtq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [gtq_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gtq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    import gtq_pkg::*;

    // hold a stalled result word
    `GTQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // an empty result carries member zero
    `GTQ_ASSERT_NOW(a_empty_zero, m_tvalid && m_tuser, m_tdata == '0, "empty result with nonzero member")

    // one word in work at a time
    `GTQ_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "word taken while busy")

    // a dequeue is only taken when the result slot is free or draining
    `GTQ_ASSERT_NOW(a_deq_slot, s_tvalid && s_tready && s_tuser == CMD_DEQ, !m_tvalid || m_tready, "dequeue taken with result slot full")

endmodule

bind grouped_team_queue gtq_checker u_gtq_checker (.*);

FILE: tb/sv/tb_grouped_team_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grouped_team_queue
// Self-checking bench for the grouped team queue. Words are fed from a queue
// with random bursts and gaps. Every accepted word updates a behavioral copy
// of the member lists and the class ring. Each dequeue result is compared in
// order against that copy while the receiver stalls on its own pattern,
// including one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_grouped_team_queue;
    import gtq_pkg::*;

    localparam int         N_MEMBERS  = DEF_MAX_MEMBERS;
    localparam int         N_CLASSES  = DEF_MAX_CLASSES;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         N_RANDOM   = 1180;
    localparam int         MEM_POOL_N = 24;
    localparam int         CLS_POOL_N = 6;
    localparam int         HOLD_AFTER = 80;
    localparam int         HOLD_LEN   = 300;
    localparam int         DRAIN_CYC  = 20;
    localparam int         IDLE_LIMIT = 6000;

    localparam int RX_OPEN = 0;
    localparam int RX_HALF = 1;
    localparam int RX_SLOW = 2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [ID_W-1:0]  member;
        logic [CLS_W-1:0] cls;
    } t_word;

    typedef struct packed {
        logic [ID_W-1:0] member;
        logic            empty;
    } t_deq_res;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // member_id, class_id
    logic [S_TUSER_W-1:0]   s_tuser  = '0;  // command
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // member_out
    logic                   m_tuser;        // empty_res

    grouped_team_queue u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // team queue shadow state
    logic [CLS_W-1:0] mem_cls     [N_MEMBERS];
    logic             mem_known   [N_MEMBERS];
    logic             mem_queued  [N_MEMBERS];
    logic [ID_W-1:0]  mem_next    [N_MEMBERS];
    logic [ID_W-1:0]  cls_head    [N_CLASSES];
    logic [ID_W-1:0]  cls_tail    [N_CLASSES];
    logic             cls_waiting [N_CLASSES];
    logic [CLS_W-1:0] cls_ring    [N_CLASSES];
    logic [CLS_W-1:0] ring_head;
    logic [CLS_W:0]   ring_count;

    t_word    word_q[$];
    t_deq_res deq_expect_q[$];
    t_word    cur_word;

    int n_total;
    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int burst_left = 0;
    int gap_left   = 0;
    int hold_left  = 0;
    bit hold_done  = 0;
    int rx_mode    = RX_OPEN;
    int rx_left    = 0;
    int idle_cnt   = 0;

    logic [ID_W-1:0]  member_pool [MEM_POOL_N];
    logic [CLS_W-1:0] class_pool  [CLS_POOL_N];

    function automatic void team_queue_step(input t_word w);
        logic [CLS_W-1:0] c;
        logic [ID_W-1:0]  m;
        t_deq_res         r;
        case (w.cmd)
            CMD_LOAD: begin
                mem_cls[w.member]   = w.cls;
                mem_known[w.member] = 1'b1;
            end
            CMD_ENQ: begin
                m = w.member;
                if (mem_known[m] && !mem_queued[m]) begin
                    c = mem_cls[m];
                    mem_queued[m] = 1'b1;
                    if (cls_waiting[c]) begin
                        mem_next[cls_tail[c]] = m;
                        cls_tail[c] = m;
                    end else begin
                        // new class joins the ring at its tail
                        cls_ring[CLS_W'(ring_head + ring_count)] = c;
                        cls_head[c]    = m;
                        cls_tail[c]    = m;
                        cls_waiting[c] = 1'b1;
                        if (ring_count < N_CLASSES)
                            ring_count++;
                    end
                end
            end
            CMD_DEQ: begin
                if (ring_count == 0) begin
                    r.member = '0;
                    r.empty  = 1'b1;
                end else begin
                    c = cls_ring[ring_head];
                    m = cls_head[c];
                    mem_queued[m] = 1'b0;
                    if (m == cls_tail[c]) begin
                        cls_waiting[c] = 1'b0;
                        ring_head++;
                        ring_count--;
                    end else begin
                        cls_head[c] = mem_next[m];
                    end
                    r.member = m;
                    r.empty  = 1'b0;
                end
                deq_expect_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    task automatic add_word(input logic [1:0] cmd, input int m, input int c);
        t_word w;
        w.cmd    = cmd;
        w.member = ID_W'(m);
        w.cls    = CLS_W'(c);
        word_q.push_back(w);
    endtask

    initial begin
        int r;
        for (int i = 0; i < N_MEMBERS; i++) begin
            mem_cls[i]    = '0;
            mem_known[i]  = 1'b0;
            mem_queued[i] = 1'b0;
            mem_next[i]   = '0;
        end
        for (int i = 0; i < N_CLASSES; i++) begin
            cls_head[i]    = '0;
            cls_tail[i]    = '0;
            cls_waiting[i] = 1'b0;
            cls_ring[i]    = '0;
        end
        ring_head  = '0;
        ring_count = '0;

        // empty queue, unused code, unknown member
        add_word(CMD_DEQ,    0,     0);
        add_word(CMD_UNUSED, 1023,  1023);
        add_word(CMD_ENQ,    5,     0);
        add_word(CMD_LOAD,   0,     0);
        add_word(CMD_LOAD,   1023,  1023);
        add_word(CMD_LOAD,   'h155, 'h2AA);
        add_word(CMD_LOAD,   'h2AA, 'h155);
        add_word(CMD_LOAD,   7,     0);
        add_word(CMD_ENQ,    1023,  0);
        add_word(CMD_ENQ,    0,     0);
        add_word(CMD_ENQ,    'h155, 0);
        // joins behind member 0, ahead of the later class
        add_word(CMD_ENQ,    7,     0);
        // already queued
        add_word(CMD_ENQ,    0,     0);
        // reload while queued: place kept, new class on next enqueue
        add_word(CMD_LOAD,   0,     'h2AA);
        add_word(CMD_ENQ,    'h2AA, 0);
        add_word(CMD_DEQ,    0,     0);
        add_word(CMD_DEQ,    0,     0);
        add_word(CMD_ENQ,    0,     0);
        add_word(CMD_DEQ,    0,     0);
        add_word(CMD_DEQ,    0,     0);
        add_word(CMD_DEQ,    0,     0);
        add_word(CMD_DEQ,    0,     0);
        add_word(CMD_DEQ,    0,     0);

        foreach (member_pool[i]) member_pool[i] = ID_W'($urandom_range(0, N_MEMBERS - 1));
        foreach (class_pool[i])  class_pool[i]  = CLS_W'($urandom_range(0, N_CLASSES - 1));

        for (int i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            if (r < 22)
                add_word(CMD_LOAD, member_pool[$urandom_range(0, MEM_POOL_N - 1)],
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, N_CLASSES - 1)
                                                     : class_pool[$urandom_range(0, CLS_POOL_N - 1)]);
            else if (r < 60)
                add_word(CMD_ENQ,
                         ($urandom_range(0, 19) == 0) ? $urandom_range(0, N_MEMBERS - 1)
                                                      : member_pool[$urandom_range(0, MEM_POOL_N - 1)],
                         $urandom_range(0, N_CLASSES - 1));
            else if (r < 95)
                add_word(CMD_DEQ, $urandom_range(0, N_MEMBERS - 1), $urandom_range(0, N_CLASSES - 1));
            else
                add_word(CMD_UNUSED, $urandom_range(0, N_MEMBERS - 1),
                         $urandom_range(0, N_CLASSES - 1));
        end
        n_total = word_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || deq_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_errors == 0)
            $display("grouped_team_queue test passed");
        else
            $display("grouped_team_queue test failed");
        $finish;
    end

    // sender: bursts of words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                team_queue_step(cur_word);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    cur_word = word_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W - ID_W - CLS_W){1'b0}}, cur_word.cls, cur_word.member};
                    s_tuser  <= cur_word.cmd;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: phases of open, half and slow acceptance, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_done = 1;
            hold_left = HOLD_LEN;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_OPEN, RX_SLOW);
                rx_left = $urandom_range(10, 80);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN: m_tready <= 1'b1;
                RX_HALF: m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_deq_res want;
        if (i_rst_n && m_tvalid && m_tready) begin
            n_results++;
            if (deq_expect_q.size() == 0) begin
                $error("unexpected word: member_out %0d, empty_res %0d",
                       m_tdata[ID_W-1:0], m_tuser);
                n_errors++;
            end else begin
                want = deq_expect_q.pop_front();
                if (m_tdata[ID_W-1:0] !== want.member) begin
                    $error("member_out mismatch: expected %0d, got %0d",
                           want.member, m_tdata[ID_W-1:0]);
                    n_errors++;
                end
                if (m_tuser !== want.empty) begin
                    $error("empty_res mismatch: expected %0d, got %0d", want.empty, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: covers the clearing pass and the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("grouped_team_queue test failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/gtq_pkg.sv
hdl/gtq_ram.sv
hdl/grouped_team_queue.sv
hdl/gtq_checker.sv
tb/sv/tb_grouped_team_queue.sv
